// ===== rtl/core/hnf_pkg.sv =====
package hnf_pkg;

	localparam int unsigned FLASH_BYTES_DEF  = 65536;
	localparam int unsigned SECTOR_BYTES_DEF = 16384;
	localparam int unsigned HDR_BYTES        = 6;

	localparam logic [30:0] ADDR_UNLOCK1 = 31'h555;
	localparam logic [30:0] ADDR_UNLOCK2 = 31'h2AA;

	localparam logic [15:0] CMD_UNLOCK1     = 16'h00AA;
	localparam logic [15:0] CMD_UNLOCK2     = 16'h0055;
	localparam logic [15:0] CMD_PROGRAM     = 16'h00A0;
	localparam logic [15:0] CMD_ERASE_SETUP = 16'h0080;
	localparam logic [15:0] CMD_RESET       = 16'h0038;
	localparam logic [15:0] CMD_CHIP_ERASE  = 16'h0010;
	localparam logic [15:0] CMD_SECT_ERASE  = 16'h0030;
	localparam logic [15:0] CMD_STATUS      = 16'h0070;
	localparam logic [15:0] STATUS_WORD     = 16'h0080;
	localparam logic [7:0]  ERASED_BYTE     = 8'hFF;

	typedef struct packed {
		logic       op;
		logic       cs_level;
		logic [7:0] bus_byte;
	} in_item_t;

	typedef struct packed {
		logic       read_valid;
		logic [7:0] read_byte;
		logic       program_fail;
		logic       out_of_range;
	} out_item_t;

	// controller states
	typedef enum logic [3:0] {
		CTL_CLEAR = 4'b0001,
		CTL_IDLE  = 4'b0010,
		CTL_EXEC  = 4'b0100,
		CTL_ERASE = 4'b1000
	} ctl_state_t;

	// flash command sequencer states
	typedef enum logic [8:0] {
		CS_CMD0       = 9'b000000001,
		CS_CMD1       = 9'b000000010,
		CS_CMD2       = 9'b000000100,
		CS_CMD3       = 9'b000001000,
		CS_CMD4       = 9'b000010000,
		CS_CMD5       = 9'b000100000,
		CS_PROG_START = 9'b001000000,
		CS_PROG       = 9'b010000000,
		CS_STATUS     = 9'b100000000
	} cmd_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic sweep;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic erase_req;
		logic sweep_done;
	} dp_status_t;

endpackage

// ===== rtl/core/hyperbus_nor_flash_command_engine.sv =====
// channel  handshake            payload                                  per handshake
// in       in_valid / in_ready  in_item  (op, cs_level, bus_byte)        one bus event
// out      out_valid/out_ready  out_item (read_valid, read_byte,         one result
//                               program_fail, out_of_range)
// Each item goes through an accept step, which takes it and reads the array, and an
// update step, which updates the command state and loads the output register; a new
// item is accepted only after the update step. After reset the array is swept to 0xFF
// with in_ready low. A sector erase or a chip erase holds in_ready low while the sector
// or the whole array is swept to 0xFF. A result waiting in the output register does not
// block acceptance; only the update step waits for the output register to free.
module hyperbus_nor_flash_command_engine #(
	parameter int unsigned FLASH_BYTES  = hnf_pkg::FLASH_BYTES_DEF,
	parameter int unsigned SECTOR_BYTES = hnf_pkg::SECTOR_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hnf_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output hnf_pkg::out_item_t out_item
);

	hnf_pkg::ctl_cmd_t   cmd;
	hnf_pkg::dp_status_t status;

	hnf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	hnf_datapath #(
		.FLASH_BYTES (FLASH_BYTES),
		.SECTOR_BYTES(SECTOR_BYTES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cmd      (cmd),
		.status   (status)
	);

endmodule

// ===== rtl/core/hnf_ram.sv =====
module hnf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/hnf_ctrl.sv =====
module hnf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hnf_pkg::dp_status_t status,
	output hnf_pkg::ctl_cmd_t   cmd
);

	hnf_pkg::ctl_state_t state_q, state_d;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		case (state_q)
			hnf_pkg::CTL_CLEAR: begin
				cmd.sweep = 1'b1;
				if (status.sweep_done) begin
					state_d = hnf_pkg::CTL_IDLE;
				end
			end
			hnf_pkg::CTL_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = hnf_pkg::CTL_EXEC;
				end
			end
			hnf_pkg::CTL_EXEC: begin
				// hold until the output slot can take the result
				if (status.out_free) begin
					cmd.exec = 1'b1;
					state_d  = status.erase_req ? hnf_pkg::CTL_ERASE : hnf_pkg::CTL_IDLE;
				end
			end
			hnf_pkg::CTL_ERASE: begin
				cmd.sweep = 1'b1;
				if (status.sweep_done) begin
					state_d = hnf_pkg::CTL_IDLE;
				end
			end
			default: begin
				state_d = hnf_pkg::CTL_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hnf_pkg::CTL_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/hnf_datapath.sv =====
module hnf_datapath #(
	parameter int unsigned FLASH_BYTES  = hnf_pkg::FLASH_BYTES_DEF,
	parameter int unsigned SECTOR_BYTES = hnf_pkg::SECTOR_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hnf_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output hnf_pkg::out_item_t  out_item,
	input  hnf_pkg::ctl_cmd_t   cmd,
	output hnf_pkg::dp_status_t status
);

	localparam int unsigned AW = $clog2(FLASH_BYTES);
	localparam logic [31:0] FLASH_LIMIT = 32'(FLASH_BYTES);
	localparam logic [31:0] SECTOR_SIZE = 32'(SECTOR_BYTES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(FLASH_BYTES - 1);

	hnf_pkg::in_item_t  item_q;
	hnf_pkg::cmd_state_t cst_q, cst_d;
	logic               phase_data_q, phase_data_d;
	logic [2:0]         left_q, left_d;
	logic [47:0]        hdr_q, hdr_d;
	logic [31:0]        addr_q, addr_d;
	logic [15:0]        hcmd_q, hcmd_d;
	logic [1:0]         hcnt_q, hcnt_d;
	logic [AW-1:0]      sweep_q, sweep_end_q;
	logic               out_valid_q;
	hnf_pkg::out_item_t out_item_q, res;

	logic [7:0]    rdata;
	logic [7:0]    prog_byte;
	logic          prog_we;
	logic          chip_erase, sect_erase;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [15:0]   full_cmd;
	logic          at555, at2aa;
	logic [31:0]   sect_base, sect_lim;
	logic [AW-1:0] sect_end;
	logic [2:0]    left_dec;

	assign full_cmd  = {item_q.bus_byte, hcmd_q[7:0]};
	assign at555     = addr_q[31:1] == hnf_pkg::ADDR_UNLOCK1;
	assign at2aa     = addr_q[31:1] == hnf_pkg::ADDR_UNLOCK2;
	assign left_dec  = (left_q != 3'd0) ? left_q - 3'd1 : 3'd0;
	assign sect_base = addr_q & ~(SECTOR_SIZE - 32'd1);
	assign sect_lim  = sect_base + SECTOR_SIZE;
	// clip the sector at the end of the array
	assign sect_end  = (sect_lim > FLASH_LIMIT) ? LAST_ADDR : AW'(sect_lim - 32'd1);

	always_comb begin
		cst_d        = cst_q;
		phase_data_d = phase_data_q;
		left_d       = left_q;
		hdr_d        = hdr_q;
		addr_d       = addr_q;
		hcmd_d       = hcmd_q;
		hcnt_d       = hcnt_q;
		res          = '0;
		prog_we      = 1'b0;
		prog_byte    = rdata & item_q.bus_byte;
		chip_erase   = 1'b0;
		sect_erase   = 1'b0;
		if (!item_q.op) begin
			phase_data_d = 1'b0;
			left_d       = 3'(hnf_pkg::HDR_BYTES);
			if (!item_q.cs_level) begin
				if (cst_q == hnf_pkg::CS_PROG_START) begin
					cst_d = hnf_pkg::CS_PROG;
				end else if (cst_q == hnf_pkg::CS_PROG) begin
					cst_d = hnf_pkg::CS_CMD0;
				end
			end
		end else if (!phase_data_q) begin
			hdr_d  = {hdr_q[39:0], item_q.bus_byte};
			left_d = left_dec;
			if (left_dec == 3'd0) begin
				phase_data_d = 1'b1;
				addr_d       = {hdr_d[44:16], hdr_d[2:0]} & 32'hFFFF_FFFE;
			end
		end else begin
			addr_d = addr_q + 32'd1;
			if (addr_q >= FLASH_LIMIT) begin
				res.out_of_range = 1'b1;
			end else if (hdr_q[47]) begin
				res.read_valid = 1'b1;
				if (cst_q == hnf_pkg::CS_STATUS) begin
					res.read_byte = hcmd_q[7:0];
					hcmd_d        = {8'h00, hcmd_q[15:8]};
					hcnt_d        = (hcnt_q != 2'd0) ? hcnt_q - 2'd1 : 2'd0;
					if (hcnt_d == 2'd0) begin
						cst_d = hnf_pkg::CS_CMD0;
					end
				end else begin
					res.read_byte = rdata;
				end
			end else if (cst_q == hnf_pkg::CS_PROG) begin
				prog_we          = 1'b1;
				res.program_fail = prog_byte != item_q.bus_byte;
			end else if (cst_q == hnf_pkg::CS_STATUS) begin
				// a write breaks off the status read
				cst_d  = hnf_pkg::CS_CMD0;
				hcmd_d = '0;
				hcnt_d = '0;
			end else if (hcnt_q == 2'd0) begin
				hcmd_d = {8'h00, item_q.bus_byte};
				hcnt_d = 2'd1;
			end else begin
				hcmd_d = '0;
				hcnt_d = '0;
				case (cst_q)
					hnf_pkg::CS_CMD0: begin
						if (at555 && full_cmd == hnf_pkg::CMD_UNLOCK1) begin
							cst_d = hnf_pkg::CS_CMD1;
						end else if (at555 && full_cmd == hnf_pkg::CMD_STATUS) begin
							cst_d  = hnf_pkg::CS_STATUS;
							hcnt_d = 2'd2;
							hcmd_d = hnf_pkg::STATUS_WORD;
						end
					end
					hnf_pkg::CS_CMD1: begin
						if (at2aa && full_cmd == hnf_pkg::CMD_UNLOCK2) begin
							cst_d = hnf_pkg::CS_CMD2;
						end
					end
					hnf_pkg::CS_CMD2: begin
						if (at555 && full_cmd == hnf_pkg::CMD_PROGRAM) begin
							cst_d = hnf_pkg::CS_PROG_START;
						end else if (at555 && full_cmd == hnf_pkg::CMD_ERASE_SETUP) begin
							cst_d = hnf_pkg::CS_CMD3;
						end else if (at555 && full_cmd == hnf_pkg::CMD_RESET) begin
							cst_d = hnf_pkg::CS_CMD0;
						end
					end
					hnf_pkg::CS_CMD3: begin
						if (at555 && full_cmd == hnf_pkg::CMD_UNLOCK1) begin
							cst_d = hnf_pkg::CS_CMD4;
						end
					end
					hnf_pkg::CS_CMD4: begin
						if (at2aa && full_cmd == hnf_pkg::CMD_UNLOCK2) begin
							cst_d = hnf_pkg::CS_CMD5;
						end
					end
					hnf_pkg::CS_CMD5: begin
						if (at555 && full_cmd == hnf_pkg::CMD_CHIP_ERASE) begin
							chip_erase = 1'b1;
							cst_d      = hnf_pkg::CS_CMD0;
						end else if (full_cmd == hnf_pkg::CMD_SECT_ERASE) begin
							sect_erase = 1'b1;
							cst_d      = hnf_pkg::CS_CMD0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign status.out_free   = !out_valid_q || out_ready;
	assign status.erase_req  = chip_erase || sect_erase;
	assign status.sweep_done = sweep_q == sweep_end_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sweep_q;
		ram_wdata = hnf_pkg::ERASED_BYTE;
		if (cmd.sweep) begin
			ram_we = 1'b1;
		end else if (cmd.exec && prog_we) begin
			ram_we    = 1'b1;
			ram_waddr = addr_q[AW-1:0];
			ram_wdata = prog_byte;
		end
	end

	hnf_ram #(
		.WIDTH(8),
		.DEPTH(FLASH_BYTES)
	) u_array (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.capture),
		.raddr(addr_q[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
		end
		if (cmd.exec) begin
			out_item_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q        <= hnf_pkg::CS_CMD0;
			phase_data_q <= 1'b0;
			left_q       <= 3'(hnf_pkg::HDR_BYTES);
			hdr_q        <= '0;
			addr_q       <= '0;
			hcmd_q       <= '0;
			hcnt_q       <= '0;
			sweep_q      <= '0;
			sweep_end_q  <= LAST_ADDR;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.exec) begin
				cst_q        <= cst_d;
				phase_data_q <= phase_data_d;
				left_q       <= left_d;
				hdr_q        <= hdr_d;
				addr_q       <= addr_d;
				hcmd_q       <= hcmd_d;
				hcnt_q       <= hcnt_d;
			end
			// load the erase range, then advance one byte a cycle
			if (cmd.exec && chip_erase) begin
				sweep_q     <= '0;
				sweep_end_q <= LAST_ADDR;
			end else if (cmd.exec && sect_erase) begin
				sweep_q     <= sect_base[AW-1:0];
				sweep_end_q <= sect_end;
			end else if (cmd.sweep) begin
				sweep_q <= sweep_q + AW'(1);
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== bench/tb_hyperbus_nor_flash_command_engine.sv =====
`timescale 1ns / 1ps

module tb_hyperbus_nor_flash_command_engine;
	import hnf_pkg::*;

	localparam int unsigned QUIET_LIMIT = 400000;
	localparam int unsigned RECV_HOLD   = 400;
	localparam int unsigned IDLE_PCT    = 31;

	typedef struct {
		bit       pause;
		in_item_t item;
	} staged_t;

	logic      clk      = 1'b0;
	logic      arst_n   = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item  = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	staged_t     pending[$];
	out_item_t   due_results[$];
	bit          pause_next;
	int unsigned items_in;
	int unsigned items_out;
	int unsigned errors = 0;
	int unsigned quiet_cycles = 0;
	int unsigned hold_left;
	bit          hold_done;

	// shadow of the flash and its command sequencer
	logic [7:0]  flash_mem [0:FLASH_BYTES_DEF-1];
	cmd_state_t  seq_state;
	bit          in_data_phase;
	int          hdr_left;
	logic [47:0] hdr_bits;
	logic [31:0] run_addr;
	logic [15:0] half_word;
	logic [1:0]  half_cnt;

	hyperbus_nor_flash_command_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #5 clk = ~clk;

	task automatic erase_range(input logic [31:0] base, input int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			if (base + i < FLASH_BYTES_DEF)
				flash_mem[base + i] = ERASED_BYTE;
		end
	endtask

	task automatic flash_reset();
		erase_range(32'd0, FLASH_BYTES_DEF);
		seq_state     = CS_CMD0;
		in_data_phase = 1'b0;
		hdr_left      = HDR_BYTES;
		hdr_bits      = '0;
		run_addr      = '0;
		half_word     = '0;
		half_cnt      = '0;
	endtask

	task automatic sequence_command(input logic [31:0] a, input logic [15:0] word);
		bit at555;
		bit at2aa;
		at555 = (a[31:1] == ADDR_UNLOCK1);
		at2aa = (a[31:1] == ADDR_UNLOCK2);
		case (seq_state)
			CS_CMD0: begin
				if (at555 && word == CMD_UNLOCK1)
					seq_state = CS_CMD1;
				else if (at555 && word == CMD_STATUS) begin
					seq_state = CS_STATUS;
					half_cnt  = 2'd2;
					half_word = STATUS_WORD;
				end
			end
			CS_CMD1: if (at2aa && word == CMD_UNLOCK2) seq_state = CS_CMD2;
			CS_CMD2: begin
				if (at555 && word == CMD_PROGRAM)
					seq_state = CS_PROG_START;
				else if (at555 && word == CMD_ERASE_SETUP)
					seq_state = CS_CMD3;
				else if (at555 && word == CMD_RESET)
					seq_state = CS_CMD0;
			end
			CS_CMD3: if (at555 && word == CMD_UNLOCK1) seq_state = CS_CMD4;
			CS_CMD4: if (at2aa && word == CMD_UNLOCK2) seq_state = CS_CMD5;
			CS_CMD5: begin
				if (at555 && word == CMD_CHIP_ERASE) begin
					erase_range(32'd0, FLASH_BYTES_DEF);
					seq_state = CS_CMD0;
				end else if (word == CMD_SECT_ERASE) begin
					erase_range(a - (a % SECTOR_BYTES_DEF), SECTOR_BYTES_DEF);
					seq_state = CS_CMD0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic flash_step(input in_item_t it, output out_item_t res);
		logic [31:0] a;
		logic [7:0]  merged;
		logic [15:0] word;
		res = '0;
		if (!it.op) begin
			in_data_phase = 1'b0;
			hdr_left      = HDR_BYTES;
			if (!it.cs_level) begin
				if (seq_state == CS_PROG_START)
					seq_state = CS_PROG;
				else if (seq_state == CS_PROG)
					seq_state = CS_CMD0;
			end
		end else if (!in_data_phase) begin
			hdr_bits = {hdr_bits[39:0], it.bus_byte};
			if (hdr_left > 0)
				hdr_left--;
			if (hdr_left == 0) begin
				in_data_phase = 1'b1;
				run_addr      = {hdr_bits[44:16], hdr_bits[2:1], 1'b0};
			end
		end else begin
			a = run_addr;
			if (a >= FLASH_BYTES_DEF) begin
				res.out_of_range = 1'b1;
			end else if (hdr_bits[47]) begin
				res.read_valid = 1'b1;
				if (seq_state == CS_STATUS) begin
					res.read_byte = half_word[7:0];
					half_word     = half_word >> 8;
					if (half_cnt > 0)
						half_cnt--;
					if (half_cnt == 0)
						seq_state = CS_CMD0;
				end else begin
					res.read_byte = flash_mem[a];
				end
			end else if (seq_state == CS_PROG) begin
				merged = flash_mem[a] & it.bus_byte;
				if (merged != it.bus_byte)
					res.program_fail = 1'b1;
				flash_mem[a] = merged;
			end else if (seq_state == CS_STATUS) begin
				// drop the byte and abort the status read
				seq_state = CS_CMD0;
				half_word = '0;
				half_cnt  = '0;
			end else if (half_cnt == 0) begin
				half_word = {8'h00, it.bus_byte};
				half_cnt  = 2'd1;
			end else begin
				word      = {it.bus_byte, half_word[7:0]};
				half_word = '0;
				half_cnt  = '0;
				sequence_command(a, word);
			end
			run_addr = a + 32'd1;
		end
	endtask

	// stimulus builders
	task automatic push_item(input bit op, input bit cs, input logic [7:0] b);
		staged_t s;
		s.pause            = pause_next;
		s.item.op          = op;
		s.item.cs_level    = cs;
		s.item.bus_byte    = b;
		pause_next         = 1'b0;
		pending.push_back(s);
	endtask

	task automatic push_cs(input bit level);
		push_item(1'b0, level, 8'($urandom));
	endtask

	task automatic push_header(input bit rd, input logic [31:0] a);
		logic [47:0] h;
		h = {rd, 2'($urandom), a[31:3], 13'($urandom), a[2:0]};
		for (int i = 5; i >= 0; i--)
			push_item(1'b1, 1'($urandom), h[i*8 +: 8]);
	endtask

	task automatic push_data(input int n);
		repeat (n) push_item(1'b1, 1'($urandom), 8'($urandom));
	endtask

	task automatic push_cmd(input logic [30:0] word_addr, input logic [15:0] word);
		push_cs(1'b1);
		push_header(1'b0, {word_addr, 1'b0});
		push_item(1'b1, 1'($urandom), word[7:0]);
		push_item(1'b1, 1'($urandom), word[15:8]);
	endtask

	task automatic push_unlock();
		push_cmd(ADDR_UNLOCK1, CMD_UNLOCK1);
		push_cmd(ADDR_UNLOCK2, CMD_UNLOCK2);
	endtask

	task automatic push_read(input logic [31:0] a, input int n);
		push_cs(1'b1);
		push_header(1'b1, a);
		push_data(n);
	endtask

	task automatic push_program(input logic [31:0] a, input int n, input bit stray_cmd,
			input bit use_fill, input logic [7:0] fill);
		// leave any open program window first
		push_cs(1'b0);
		push_cs(1'b0);
		push_unlock();
		push_cmd(ADDR_UNLOCK1, CMD_PROGRAM);
		if (stray_cmd)
			push_cmd(ADDR_UNLOCK1, 16'($urandom));
		push_cs(1'b0);
		push_header(1'b0, a);
		if (use_fill)
			repeat (n) push_item(1'b1, 1'($urandom), fill);
		else
			push_data(n);
		push_cs(1'b0);
	endtask

	task automatic push_erase(input bit whole_chip, input logic [30:0] word_addr);
		push_cs(1'b0);
		push_cs(1'b0);
		push_unlock();
		push_cmd(ADDR_UNLOCK1, CMD_ERASE_SETUP);
		push_unlock();
		if (whole_chip)
			push_cmd(ADDR_UNLOCK1, CMD_CHIP_ERASE);
		else
			push_cmd(word_addr, CMD_SECT_ERASE);
	endtask

	task automatic push_status(input int n, input bit then_write);
		push_cmd(ADDR_UNLOCK1, CMD_STATUS);
		push_cs(1'b1);
		push_header(!then_write, 32'($urandom_range(0, FLASH_BYTES_DEF - 8)));
		push_data(n);
	endtask

	function automatic logic [31:0] rand_addr();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return {16'h0, 2'($urandom), 8'h0, 6'($urandom)};
		else if (r < 85)
			return 32'($urandom_range(0, FLASH_BYTES_DEF - 1));
		else if (r < 93)
			return FLASH_BYTES_DEF - 32'($urandom_range(1, 16));
		return $urandom;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin : drive_proc
		out_item_t   res;
		staged_t     nxt;
		int unsigned owed;
		bit          calm;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item  <= '0;
			items_in <= 0;
			flash_reset();
		end else begin
			owed = items_in - items_out;
			if (in_valid && in_ready) begin
				flash_step(in_item, res);
				due_results.push_back(res);
				items_in <= items_in + 1;
				owed++;
			end
			calm = (items_in >= 250 && items_in < 350);
			if (!in_valid || in_ready) begin
				if (pending.size() != 0 && !(pending[0].pause && owed != 0) &&
						(calm || $urandom_range(99) >= IDLE_PCT)) begin
					nxt = pending.pop_front();
					in_valid <= 1'b1;
					in_item  <= nxt.item;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin : check_proc
		out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			items_out <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				items_out <= items_out + 1;
				if (items_out == items_in) begin
					errors++;
					$display("%0t: result with nothing due: %p", $time, out_item);
				end else begin
					want = due_results.pop_front();
					if (out_item.read_valid !== want.read_valid) begin
						errors++;
						$display("%0t: read_valid expected %0b actual %0b", $time,
							want.read_valid, out_item.read_valid);
					end
					if (out_item.read_byte !== want.read_byte) begin
						errors++;
						$display("%0t: read_byte expected %02h actual %02h", $time,
							want.read_byte, out_item.read_byte);
					end
					if (out_item.program_fail !== want.program_fail) begin
						errors++;
						$display("%0t: program_fail expected %0b actual %0b", $time,
							want.program_fail, out_item.program_fail);
					end
					if (out_item.out_of_range !== want.out_of_range) begin
						errors++;
						$display("%0t: out_of_range expected %0b actual %0b", $time,
							want.out_of_range, out_item.out_of_range);
					end
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!hold_done && items_out >= 60) begin
				// hold off long enough for the block to back up its input
				hold_done <= 1'b1;
				hold_left <= RECV_HOLD;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (items_out >= 250 && items_out < 350) ||
					($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin : stim_proc
		int unsigned r;
		int          sect_left;
		int          chip_left;
		int          goal;
		pause_next   = 1'b0;
		sect_left    = 6;
		chip_left    = 2;

		// directed: erased reads, extreme program bytes, failing program
		push_read(32'h0000_0000, 3);
		push_program(32'h0000_0010, 2, 1'b0, 1'b1, 8'h5A);
		push_program(32'h0000_0010, 2, 1'b0, 1'b1, 8'hFF);
		push_program(32'h0000_0012, 2, 1'b0, 1'b1, 8'h00);
		push_read(32'h0000_0010, 4);
		// status bytes, then a status read cut short by a write
		push_status(3, 1'b0);
		push_status(1, 1'b1);
		// commands paired before the program window opens have no effect
		push_program(32'h0000_4002, 3, 1'b1, 1'b0, 8'h00);
		// unmatched command, broken unlock, reset command
		push_cmd(ADDR_UNLOCK1, 16'h1234);
		push_unlock();
		push_cmd(ADDR_UNLOCK2, CMD_PROGRAM);
		push_unlock();
		push_cmd(ADDR_UNLOCK1, CMD_RESET);
		// out of range, top of the array, running address wrap
		push_read(32'h0001_0000, 2);
		push_cs(1'b1);
		push_header(1'b0, 32'hFFFF_0000);
		push_data(2);
		push_read(32'h0000_FFFE, 4);
		push_read(32'hFFFF_FFFE, 4);
		// sector erase on the second sector, then a drain, a program and a chip erase
		push_erase(1'b0, 31'h2000);
		push_read(32'h0000_4002, 3);
		pause_next = 1'b1;
		push_program(32'h0000_C000, 2, 1'b0, 1'b1, 8'h00);
		push_erase(1'b1, ADDR_UNLOCK1);
		push_read(32'h0000_C000, 2);
		push_read(32'h0000_0010, 2);

		goal = 550;
		while (pending.size() < goal) begin
			if ($urandom_range(29) == 0)
				pause_next = 1'b1;
			r = $urandom_range(99);
			if (r < 30)
				push_program(rand_addr(), $urandom_range(1, 6), $urandom_range(9) == 0,
					1'b0, 8'h00);
			else if (r < 55)
				push_read(rand_addr(), $urandom_range(1, 8));
			else if (r < 63)
				push_status($urandom_range(1, 3), $urandom_range(3) == 0);
			else if (r < 67) begin
				push_unlock();
				push_cmd(ADDR_UNLOCK1, CMD_RESET);
			end else if (r < 71) begin
				push_unlock();
				push_cmd($urandom_range(1) ? ADDR_UNLOCK1 : 31'($urandom), 16'($urandom));
			end else if (r < 74 && sect_left > 0) begin
				sect_left--;
				push_erase(1'b0, 31'($urandom_range(0, FLASH_BYTES_DEF / 2 - 1)));
			end else if (r == 74 && chip_left > 0) begin
				chip_left--;
				push_erase(1'b1, ADDR_UNLOCK1);
			end else if (r < 85) begin
				push_cs(1'b1);
				push_header(1'($urandom), rand_addr());
				push_data($urandom_range(1, 4));
			end else begin
				repeat ($urandom_range(1, 8))
					push_item(1'($urandom), 1'($urandom), 8'($urandom));
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || in_valid)
			@(posedge clk);
		while (items_out != items_in)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
